### rtl/bba_pkg.sv
// Shared types, sizes and helpers for the bitmap block allocator.
// Used by bba_map_mem, bba_ctrl and bitmap_block_allocator; no dependencies.
package bba_pkg;

	// Map geometry
	localparam int MAP_WORDS   = 128;
	localparam int WORD_BITS   = 32;
	localparam int WORD_IDX_W  = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int BIT_IDX_W   = $clog2(WORD_BITS);
	localparam int COUNT_W     = $clog2(MAP_WORDS + 1);
	localparam int IDX_W       = WORD_IDX_W + BIT_IDX_W;
	localparam int LIMIT_W     = COUNT_W + BIT_IDX_W;

	// Field widths
	localparam int ACTION_W    = 2;
	localparam int BLOCK_W     = 12;
	localparam int STATUS_W    = 2;
	localparam int CFG_W       = 8;

	// Highest block index that fits in the block field
	localparam int BLOCK_LIMIT = 4095;
	localparam logic [CFG_W-1:0] ACTIVE_WORDS_RST = CFG_W'(128);

	// Request actions
	typedef logic [ACTION_W-1:0] action_t;
	localparam action_t ACT_ALLOC = 2'd0;
	localparam action_t ACT_FREE  = 2'd1;
	localparam action_t ACT_CLEAR = 2'd2;

	// Response status codes
	typedef logic [STATUS_W-1:0] status_t;
	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_FULL  = 2'd1;
	localparam status_t ST_RANGE = 2'd2;

	typedef logic [WORD_BITS-1:0] word_t;

	// Controller to map memory
	typedef struct packed {
		logic [WORD_IDX_W-1:0] rd_addr;
		logic                  wr_en;
		logic [WORD_IDX_W-1:0] wr_addr;
		word_t                 wr_data;
		logic                  clr;
	} map_req_t;

	// Finished result from the controller
	typedef struct packed {
		logic [BLOCK_W-1:0] given;
		status_t            status;
		logic               last;
	} res_t;

	// Position of the lowest clear bit (0 when the word is full)
	function automatic logic [BIT_IDX_W-1:0] lowest_clear(input word_t w);
		logic [BIT_IDX_W-1:0] pos;
		pos = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!w[i])
				pos = BIT_IDX_W'(i);
		end
		return pos;
	endfunction

endpackage

### rtl/bba_map_mem.sv
// Usage bitmap storage: one-port-write, one-port-read RAM with registered read,
// plus per-word valid flags that a clear resets together. Depends on bba_pkg.
module bba_map_mem (
	input  logic              clk,
	input  logic              arst_n,
	input  bba_pkg::map_req_t map_req,
	output bba_pkg::word_t    rdata
);

	bba_pkg::word_t                  ram_q [bba_pkg::MAP_WORDS];
	logic [bba_pkg::MAP_WORDS-1:0]   valid_q;
	bba_pkg::word_t                  raw_s1;
	logic                            valid_s1;
	logic                            zero_s1;

	// RAM array, read data registered
	always_ff @(posedge clk) begin
		if (map_req.wr_en)
			ram_q[map_req.wr_addr] <= map_req.wr_data;
		raw_s1 <= ram_q[map_req.rd_addr];
	end

	// Valid flags: a word never written since reset or clear reads as mount pattern
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			valid_s1 <= 1'b0;
			zero_s1  <= 1'b0;
		end else begin
			if (map_req.clr)
				valid_q <= '0;
			else if (map_req.wr_en)
				valid_q[map_req.wr_addr] <= 1'b1;
			valid_s1 <= valid_q[map_req.rd_addr];
			zero_s1  <= (map_req.rd_addr == '0);
		end
	end

	// Mount pattern: block 0 used, everything else free
	assign rdata = valid_s1 ? raw_s1 :
	               (zero_s1 ? bba_pkg::word_t'(1) : '0);

endmodule

### rtl/bba_ctrl.sv
// Request sequencer: first-fit scan and free as read-modify-write on the
// bitmap memory, clear as a reset of its valid flags. Depends on bba_pkg.
module bba_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  bba_pkg::action_t              action,
	input  logic [bba_pkg::BLOCK_W-1:0]   block_number,
	input  logic                          last_block,
	input  logic [bba_pkg::COUNT_W-1:0]   words,
	output bba_pkg::map_req_t             map_req,
	input  bba_pkg::word_t                map_rdata,
	output bba_pkg::res_t                 res,
	output logic                          res_valid,
	input  logic                          res_ready
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_FREE = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t                              state_q, state_d;
	logic [bba_pkg::WORD_IDX_W-1:0]      scan_idx_q, scan_idx_d;
	logic [bba_pkg::BLOCK_W-1:0]         blk_q, blk_d;
	logic                                last_q, last_d;
	logic [bba_pkg::BLOCK_W-1:0]         given_q, given_d;
	bba_pkg::status_t                    status_q, status_d;

	logic [bba_pkg::LIMIT_W-1:0]         blk_limit;
	logic [bba_pkg::BIT_IDX_W-1:0]       clr_pos;
	logic [bba_pkg::IDX_W-1:0]           hit_idx;
	logic [bba_pkg::BIT_IDX_W-1:0]       blk_bit;
	logic [bba_pkg::WORD_IDX_W-1:0]      blk_word;
	logic [bba_pkg::WORD_IDX_W-1:0]      req_word;

	// Range limit, lowest clear bit, and address decode of the held and the incoming block number
	assign blk_limit = {words, {bba_pkg::BIT_IDX_W{1'b0}}};
	assign clr_pos   = bba_pkg::lowest_clear(map_rdata);
	assign hit_idx   = {scan_idx_q, clr_pos};
	assign blk_bit   = blk_q[bba_pkg::BIT_IDX_W-1:0];
	assign blk_word  = bba_pkg::WORD_IDX_W'(blk_q >> bba_pkg::BIT_IDX_W);
	assign req_word  = bba_pkg::WORD_IDX_W'(block_number >> bba_pkg::BIT_IDX_W);

	// Next-state and memory access
	always_comb begin
		state_d    = state_q;
		scan_idx_d = scan_idx_q;
		blk_d      = blk_q;
		last_d     = last_q;
		given_d    = given_q;
		status_d   = status_q;
		map_req    = '0;
		req_ready  = 1'b0;
		res_valid  = 1'b0;

		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					blk_d    = block_number;
					last_d   = last_block;
					given_d  = '0;
					status_d = bba_pkg::ST_OK;
					state_d  = S_DONE;
					case (action)
						bba_pkg::ACT_ALLOC: begin
							if (words == '0) begin
								status_d = bba_pkg::ST_FULL;
							end else begin
								map_req.rd_addr = '0;
								scan_idx_d      = '0;
								state_d         = S_SCAN;
							end
						end
						bba_pkg::ACT_FREE: begin
							if (32'(block_number) >= 32'(blk_limit)) begin
								status_d = bba_pkg::ST_RANGE;
							end else begin
								map_req.rd_addr = req_word;
								state_d         = S_FREE;
							end
						end
						bba_pkg::ACT_CLEAR: begin
							map_req.clr = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end

			// One word a cycle: check word scan_idx_q, fetch the next
			S_SCAN: begin
				if (map_rdata != '1) begin
					if (32'(hit_idx) <= 32'(bba_pkg::BLOCK_LIMIT)) begin
						map_req.wr_en   = 1'b1;
						map_req.wr_addr = scan_idx_q;
						map_req.wr_data = map_rdata | (bba_pkg::word_t'(1) << clr_pos);
						given_d         = bba_pkg::BLOCK_W'(hit_idx);
					end else begin
						status_d = bba_pkg::ST_FULL;
					end
					state_d = S_DONE;
				end else if (32'(scan_idx_q) + 32'd1 >= 32'(words)) begin
					status_d = bba_pkg::ST_FULL;
					state_d  = S_DONE;
				end else begin
					scan_idx_d      = scan_idx_q + 1'b1;
					map_req.rd_addr = scan_idx_q + 1'b1;
				end
			end

			// Clear the block's bit in the word just read
			S_FREE: begin
				map_req.wr_en   = 1'b1;
				map_req.wr_addr = blk_word;
				map_req.wr_data = map_rdata & ~(bba_pkg::word_t'(1) << blk_bit);
				given_d         = blk_q;
				state_d         = S_DONE;
			end

			// Hand the result to the response register
			S_DONE: begin
				res_valid = 1'b1;
				if (res_ready)
					state_d = S_IDLE;
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Request and result holding registers
	always_ff @(posedge clk) begin
		scan_idx_q <= scan_idx_d;
		blk_q      <= blk_d;
		last_q     <= last_d;
		given_q    <= given_d;
		status_q   <= status_d;
	end

	assign res = '{given: given_q, status: status_q, last: last_q};

endmodule

### rtl/bitmap_block_allocator.sv
// Top level of the first-fit bitmap block allocator: config register,
// response register and assertions. Depends on bba_pkg, bba_map_mem, bba_ctrl.
//
//  channel   handshake            payload
//  request   req_valid/req_ready  action, block_number, last_block
//  response  rsp_valid/rsp_ready  given_block, status, last_done
//  config    cfg_we               cfg_data (active_words)
//
// One request at a time. Allocate reads the map from word 0 and stops at the
// first word with a clear bit; on a full map it reads all active_words words
// (active_words capped at the map size). The bitmap RAM read port, one word per
// cycle, paces the scan. Free reads the block's word and writes it back; clear
// resets the valid flags, and reset leaves the map in its mount state at once.
// A held response does not block the next request; a finished one waits for it.
module bitmap_block_allocator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  logic [bba_pkg::ACTION_W-1:0]   action,
	input  logic [bba_pkg::BLOCK_W-1:0]    block_number,
	input  logic                           last_block,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output logic [bba_pkg::BLOCK_W-1:0]    given_block,
	output logic [bba_pkg::STATUS_W-1:0]   status,
	output logic                           last_done,
	input  logic                           cfg_we,
	input  logic [bba_pkg::CFG_W-1:0]      cfg_data
);

	logic [bba_pkg::CFG_W-1:0]     active_words_q;
	logic [bba_pkg::COUNT_W-1:0]   words;
	bba_pkg::map_req_t             map_req;
	bba_pkg::word_t                map_rdata;
	bba_pkg::res_t                 res;
	logic                          res_valid;
	logic                          res_ready;
	logic                          rsp_valid_q;
	bba_pkg::res_t                 rsp_q;

	// Active word count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_words_q <= bba_pkg::ACTIVE_WORDS_RST;
		end else if (cfg_we) begin
			active_words_q <= cfg_data;
		end
	end

	// Clamp to the map size
	assign words = (32'(active_words_q) > 32'(bba_pkg::MAP_WORDS)) ?
	               bba_pkg::COUNT_W'(bba_pkg::MAP_WORDS) :
	               bba_pkg::COUNT_W'(active_words_q);

	bba_map_mem u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.map_req (map_req),
		.rdata   (map_rdata)
	);

	bba_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.action       (action),
		.block_number (block_number),
		.last_block   (last_block),
		.words        (words),
		.map_req      (map_req),
		.map_rdata    (map_rdata),
		.res          (res),
		.res_valid    (res_valid),
		.res_ready    (res_ready)
	);

	// Response register
	assign res_ready = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready)
			rsp_q <= res;
	end

	assign rsp_valid   = rsp_valid_q;
	assign given_block = rsp_q.given;
	assign status      = rsp_q.status;
	assign last_done   = rsp_q.last;

	// A map write and a map clear never coincide
	assert property (@(posedge clk) disable iff (!arst_n)
		map_req.wr_en |-> !map_req.clr)
		else $error("map write collides with clear");

	// After a map write the controller is finishing, not taking a request
	assert property (@(posedge clk) disable iff (!arst_n)
		map_req.wr_en |=> !req_ready)
		else $error("request taken right after a map write");

	// Failed requests return block 0
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status != bba_pkg::ST_OK) |-> (given_block == '0))
		else $error("failed response carries a block index");

	// A clear request completes without touching the RAM array
	assert property (@(posedge clk) disable iff (!arst_n)
		map_req.clr |=> !map_req.wr_en)
		else $error("map write straight after clear");

endmodule
